>>> rtl/core/scm_pkg.sv
package scm_pkg;

  localparam int LABEL_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int COUNT_OUT_W = 32;
  localparam int RATIO_W     = 17;
  localparam int PCW_W       = 23;
  // Quotient register holds the low bits of every ratio, the widest being percent wrong.
  localparam int QUO_W       = PCW_W;
  localparam int PCT_SCALE   = 100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_B = 2'd3;

  localparam logic [LABEL_W-1:0] SHADOW_RST   = 8'd50;
  localparam logic [LABEL_W-1:0] MOTION_RST   = 8'd255;
  localparam logic [LABEL_W-1:0] IGNORE_A_RST = 8'd85;
  localparam logic [LABEL_W-1:0] IGNORE_B_RST = 8'd170;

  // Order in which the shared divider works through the ratios of a frame.
  typedef enum logic [2:0] {
    JOB_PREC = 3'd0,
    JOB_REC  = 3'd1,
    JOB_FNR  = 3'd2,
    JOB_SPEC = 3'd3,
    JOB_FPR  = 3'd4,
    JOB_PCW  = 3'd5,
    JOB_FM   = 3'd6
  } job_t;

  localparam int NUM_JOBS = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP,
    ST_STORE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic count_en;
    logic snap;
    logic div_init;
    logic div_step;
    logic div_store;
    logic out_load;
    job_t job;
  } dp_cmd_t;

endpackage

>>> rtl/core/scm_ctrl.sv
module scm_ctrl #(
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last_pixel,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output scm_pkg::dp_cmd_t cmd
);

  localparam int NUM_W  = COUNT_BITS + 8;
  localparam int NW     = NUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(NW);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NW - 1);

  scm_pkg::state_t state_r, state_nxt;
  scm_pkg::job_t   job_r, job_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scm_pkg::ST_IDLE;
      job_r       <= scm_pkg::JOB_PREC;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == scm_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.job       = job_r;
    unique case (state_r)
      scm_pkg::ST_IDLE: begin
        cmd.count_en = in_fire;
        if (in_fire && in_last_pixel) begin
          cmd.snap  = 1'b1;
          job_nxt   = scm_pkg::JOB_PREC;
          state_nxt = scm_pkg::ST_INIT;
        end
      end
      scm_pkg::ST_INIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = scm_pkg::ST_STEP;
      end
      scm_pkg::ST_STEP: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = scm_pkg::ST_STORE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      scm_pkg::ST_STORE: begin
        cmd.div_store = 1'b1;
        if (job_r == scm_pkg::JOB_FM) begin
          state_nxt = scm_pkg::ST_FINISH;
        end else begin
          job_nxt   = scm_pkg::job_t'(job_r + 3'd1);
          state_nxt = scm_pkg::ST_INIT;
        end
      end
      scm_pkg::ST_FINISH: begin
        // The previous result must be gone before the output register is overwritten.
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = scm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

>>> rtl/core/scm_dp.sv
module scm_dp #(
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scm_pkg::dp_cmd_t                    cmd,
  input  logic                                cfg_wr_en,
  input  logic [scm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scm_pkg::LABEL_W-1:0]         cfg_data,
  input  logic [scm_pkg::LABEL_W-1:0]         in_test_pixel,
  input  logic [scm_pkg::LABEL_W-1:0]         in_truth_pixel,
  output logic [scm_pkg::COUNT_OUT_W-1:0]     out_true_pos,
  output logic [scm_pkg::COUNT_OUT_W-1:0]     out_true_neg,
  output logic [scm_pkg::COUNT_OUT_W-1:0]     out_false_pos,
  output logic [scm_pkg::COUNT_OUT_W-1:0]     out_false_neg,
  output logic [scm_pkg::RATIO_W-1:0]         out_recall,
  output logic [scm_pkg::RATIO_W-1:0]         out_specificity,
  output logic [scm_pkg::RATIO_W-1:0]         out_false_pos_rate,
  output logic [scm_pkg::RATIO_W-1:0]         out_false_neg_rate,
  output logic [scm_pkg::PCW_W-1:0]           out_percent_wrong,
  output logic [scm_pkg::RATIO_W-1:0]         out_f_measure,
  output logic [scm_pkg::RATIO_W-1:0]         out_precision
);

  localparam int CB    = COUNT_BITS;
  localparam int DEN_W = CB + 2;
  localparam int NUM_W = CB + 8;
  localparam int NW    = NUM_W + FRAC_BITS;
  localparam int QW    = scm_pkg::QUO_W;
  localparam int OW    = scm_pkg::COUNT_OUT_W;
  localparam logic [QW-1:0] ONE_FX = QW'(1) << FRAC_BITS;

  // Label configuration.
  logic [scm_pkg::LABEL_W-1:0] shadow_r, motion_r, ign_a_r, ign_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_r <= scm_pkg::SHADOW_RST;
      motion_r <= scm_pkg::MOTION_RST;
      ign_a_r  <= scm_pkg::IGNORE_A_RST;
      ign_b_r  <= scm_pkg::IGNORE_B_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        scm_pkg::REG_SHADOW:   shadow_r <= cfg_data;
        scm_pkg::REG_MOTION:   motion_r <= cfg_data;
        scm_pkg::REG_IGNORE_A: ign_a_r  <= cfg_data;
        scm_pkg::REG_IGNORE_B: ign_b_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pixel classification and saturating counters.
  logic [scm_pkg::LABEL_W-1:0] truth_map;
  logic counted, match, test_nz;
  logic [CB-1:0] tp_r, tn_r, fp_r, fn_r;
  logic [CB-1:0] tp_nxt, tn_nxt, fp_nxt, fn_nxt;

  assign truth_map = (in_truth_pixel == shadow_r) ? motion_r : in_truth_pixel;
  assign counted   = cmd.count_en && (truth_map != ign_a_r) && (truth_map != ign_b_r);
  assign match     = (in_test_pixel == truth_map);
  assign test_nz   = (in_test_pixel != '0);

  always_comb begin
    tp_nxt = tp_r;
    tn_nxt = tn_r;
    fp_nxt = fp_r;
    fn_nxt = fn_r;
    if (counted) begin
      priority if (match && test_nz) begin
        if (tp_r != '1) tp_nxt = tp_r + 1'b1;
      end else if (match) begin
        if (tn_r != '1) tn_nxt = tn_r + 1'b1;
      end else if (test_nz) begin
        if (fp_r != '1) fp_nxt = fp_r + 1'b1;
      end else begin
        if (fn_r != '1) fn_nxt = fn_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r <= '0;
      tn_r <= '0;
      fp_r <= '0;
      fn_r <= '0;
    end else if (cmd.snap) begin
      tp_r <= '0;
      tn_r <= '0;
      fp_r <= '0;
      fn_r <= '0;
    end else begin
      tp_r <= tp_nxt;
      tn_r <= tn_nxt;
      fp_r <= fp_nxt;
      fn_r <= fn_nxt;
    end
  end

  // Frame snapshot, including the last pixel.
  logic [CB-1:0] s_tp_r, s_tn_r, s_fp_r, s_fn_r;

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      s_tp_r <= tp_nxt;
      s_tn_r <= tn_nxt;
      s_fp_r <= fp_nxt;
      s_fn_r <= fn_nxt;
    end
  end

  // Operand selection for the current ratio.
  logic [DEN_W-1:0] d_tp_fp, d_tp_fn, d_tn_fp, d_total, d_fm;
  logic [NUM_W-1:0] wrong_sum, pcw_num;
  logic [NUM_W-1:0] num_sel;
  logic [DEN_W-1:0] den_sel;

  assign d_tp_fp   = DEN_W'(s_tp_r) + DEN_W'(s_fp_r);
  assign d_tp_fn   = DEN_W'(s_tp_r) + DEN_W'(s_fn_r);
  assign d_tn_fp   = DEN_W'(s_tn_r) + DEN_W'(s_fp_r);
  assign d_total   = d_tp_fp + DEN_W'(s_tn_r) + DEN_W'(s_fn_r);
  assign d_fm      = d_tp_fp + d_tp_fn;
  assign wrong_sum = NUM_W'(s_fn_r) + NUM_W'(s_fp_r);
  assign pcw_num   = wrong_sum * NUM_W'(scm_pkg::PCT_SCALE);

  always_comb begin
    unique case (cmd.job)
      scm_pkg::JOB_PREC: begin num_sel = NUM_W'(s_tp_r);       den_sel = d_tp_fp; end
      scm_pkg::JOB_REC:  begin num_sel = NUM_W'(s_tp_r);       den_sel = d_tp_fn; end
      scm_pkg::JOB_FNR:  begin num_sel = NUM_W'(s_fn_r);       den_sel = d_tp_fn; end
      scm_pkg::JOB_SPEC: begin num_sel = NUM_W'(s_tn_r);       den_sel = d_tn_fp; end
      scm_pkg::JOB_FPR:  begin num_sel = NUM_W'(s_fp_r);       den_sel = d_tn_fp; end
      scm_pkg::JOB_PCW:  begin num_sel = pcw_num;              den_sel = d_total; end
      scm_pkg::JOB_FM:   begin num_sel = NUM_W'({s_tp_r, 1'b0}); den_sel = d_fm;  end
      default:           begin num_sel = '0;                   den_sel = '0;      end
    endcase
  end

  // Restoring divider, one quotient bit per cycle.
  logic [NW-1:0]    dvd_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [QW-1:0]    quo_r;
  logic [DEN_W:0]   rem_shift, rem_diff;
  logic             q_bit;

  assign rem_shift = {rem_r, dvd_r[NW-1]};
  assign rem_diff  = rem_shift - {1'b0, den_r};
  assign q_bit     = (rem_shift >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd_r <= {num_sel, {FRAC_BITS{1'b0}}};
      den_r <= den_sel;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      rem_r <= q_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quo_r <= {quo_r[QW-2:0], q_bit};
    end
  end

  // Per-ratio results. A zero denominator selects the default: 1.0 for precision,
  // recall, specificity and F-measure (no positives at all), zero for the rest.
  logic [QW-1:0] res_r [scm_pkg::NUM_JOBS];
  logic          one_default;

  assign one_default = (cmd.job == scm_pkg::JOB_PREC) || (cmd.job == scm_pkg::JOB_REC) ||
                       (cmd.job == scm_pkg::JOB_SPEC) || (cmd.job == scm_pkg::JOB_FM);

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      if (den_r == '0) begin
        res_r[cmd.job] <= one_default ? ONE_FX : '0;
      end else begin
        res_r[cmd.job] <= quo_r;
      end
    end
  end

  // Output register.
  logic [CB+OW-1:0] tp_ext, tn_ext, fp_ext, fn_ext;
  logic [OW-1:0] o_tp_r, o_tn_r, o_fp_r, o_fn_r;
  logic [scm_pkg::RATIO_W-1:0] o_rec_r, o_spec_r, o_fpr_r, o_fnr_r, o_fm_r, o_prec_r;
  logic [scm_pkg::PCW_W-1:0]   o_pcw_r;

  assign tp_ext = {{OW{1'b0}}, s_tp_r};
  assign tn_ext = {{OW{1'b0}}, s_tn_r};
  assign fp_ext = {{OW{1'b0}}, s_fp_r};
  assign fn_ext = {{OW{1'b0}}, s_fn_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_tp_r   <= tp_ext[OW-1:0];
      o_tn_r   <= tn_ext[OW-1:0];
      o_fp_r   <= fp_ext[OW-1:0];
      o_fn_r   <= fn_ext[OW-1:0];
      o_prec_r <= res_r[scm_pkg::JOB_PREC][scm_pkg::RATIO_W-1:0];
      o_rec_r  <= res_r[scm_pkg::JOB_REC][scm_pkg::RATIO_W-1:0];
      o_fnr_r  <= res_r[scm_pkg::JOB_FNR][scm_pkg::RATIO_W-1:0];
      o_spec_r <= res_r[scm_pkg::JOB_SPEC][scm_pkg::RATIO_W-1:0];
      o_fpr_r  <= res_r[scm_pkg::JOB_FPR][scm_pkg::RATIO_W-1:0];
      o_pcw_r  <= res_r[scm_pkg::JOB_PCW][scm_pkg::PCW_W-1:0];
      o_fm_r   <= res_r[scm_pkg::JOB_FM][scm_pkg::RATIO_W-1:0];
    end
  end

  assign out_true_pos       = o_tp_r;
  assign out_true_neg       = o_tn_r;
  assign out_false_pos      = o_fp_r;
  assign out_false_neg      = o_fn_r;
  assign out_recall         = o_rec_r;
  assign out_specificity    = o_spec_r;
  assign out_false_pos_rate = o_fpr_r;
  assign out_false_neg_rate = o_fnr_r;
  assign out_percent_wrong  = o_pcw_r;
  assign out_f_measure      = o_fm_r;
  assign out_precision      = o_prec_r;

endmodule

>>> rtl/core/segmentation_confusion_metrics.sv
// Confusion-matrix and F-measure statistics for binary segmentation masks.
// The input channel (in_valid/in_ready) carries one transaction per pixel: a test
// label, a ground-truth label and a last-pixel flag. Pixels are taken one per cycle
// while in_ready is high and counted as true/false positive/negative in saturating
// counters. The transaction with last_pixel set closes the frame: the counts
// including that pixel are snapshotted, the counters clear, and a single shared
// restoring divider computes seven ratios one after another, one quotient bit per
// cycle. in_ready is low until the result is loaded into the output register.
// The cfg port writes one label register per cycle; the user must use it only while
// the block is idle, which the block itself does not enforce.
// The result channel (out_valid/out_ready) presents counts and ratios from an output
// register; while a result waits for the receiver, pixels of the next frame are
// still accepted. If the next frame ends before the receiver takes the pending
// result, the block holds its new result and keeps in_ready low until it can load it.
// Reset (rst_n, synchronous) clears the counters, drops out_valid and restores the
// default labels: shadow 50, motion 255, ignore 85 and 170.
module segmentation_confusion_metrics #(
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scm_pkg::LABEL_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [scm_pkg::LABEL_W-1:0]     in_test_pixel,
  input  logic [scm_pkg::LABEL_W-1:0]     in_truth_pixel,
  input  logic                            in_last_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [scm_pkg::COUNT_OUT_W-1:0] out_true_pos,
  output logic [scm_pkg::COUNT_OUT_W-1:0] out_true_neg,
  output logic [scm_pkg::COUNT_OUT_W-1:0] out_false_pos,
  output logic [scm_pkg::COUNT_OUT_W-1:0] out_false_neg,
  output logic [scm_pkg::RATIO_W-1:0]     out_recall,
  output logic [scm_pkg::RATIO_W-1:0]     out_specificity,
  output logic [scm_pkg::RATIO_W-1:0]     out_false_pos_rate,
  output logic [scm_pkg::RATIO_W-1:0]     out_false_neg_rate,
  output logic [scm_pkg::PCW_W-1:0]       out_percent_wrong,
  output logic [scm_pkg::RATIO_W-1:0]     out_f_measure,
  output logic [scm_pkg::RATIO_W-1:0]     out_precision
);

  // Command bundle from the sequencer to the datapath.
  scm_pkg::dp_cmd_t cmd;

  // The controller owns both handshakes and steps the divider through the ratios.
  scm_ctrl #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_pixel (in_last_pixel),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd)
  );

  // The datapath holds the label registers, counters, divider and output register.
  scm_dp #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_test_pixel      (in_test_pixel),
    .in_truth_pixel     (in_truth_pixel),
    .out_true_pos       (out_true_pos),
    .out_true_neg       (out_true_neg),
    .out_false_pos      (out_false_pos),
    .out_false_neg      (out_false_neg),
    .out_recall         (out_recall),
    .out_specificity    (out_specificity),
    .out_false_pos_rate (out_false_pos_rate),
    .out_false_neg_rate (out_false_neg_rate),
    .out_percent_wrong  (out_percent_wrong),
    .out_f_measure      (out_f_measure),
    .out_precision      (out_precision)
  );

endmodule

>>> tb/confusion_metrics_checker.sv
// Watches the pixel and result channels of the confusion-metrics block, keeps
// its own tally of the four pixel classes and compares every result
// transaction with the statistics expected for the frame that produced it.
module confusion_metrics_checker
  import scm_pkg::*;
#(
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [LABEL_W-1:0]     cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [LABEL_W-1:0]     in_test_pixel,
  input  logic [LABEL_W-1:0]     in_truth_pixel,
  input  logic                   in_last_pixel,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [COUNT_OUT_W-1:0] out_true_pos,
  input  logic [COUNT_OUT_W-1:0] out_true_neg,
  input  logic [COUNT_OUT_W-1:0] out_false_pos,
  input  logic [COUNT_OUT_W-1:0] out_false_neg,
  input  logic [RATIO_W-1:0]     out_recall,
  input  logic [RATIO_W-1:0]     out_specificity,
  input  logic [RATIO_W-1:0]     out_false_pos_rate,
  input  logic [RATIO_W-1:0]     out_false_neg_rate,
  input  logic [PCW_W-1:0]       out_percent_wrong,
  input  logic [RATIO_W-1:0]     out_f_measure,
  input  logic [RATIO_W-1:0]     out_precision,
  output int                     mismatches,
  output int                     frames_outstanding,
  output int                     frames_checked
);

  localparam logic [63:0] COUNT_CEIL  = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] UNITY       = 64'd1 << FRAC_BITS;
  // Beyond this many lines the mismatches are still counted but no longer printed.
  localparam int          MAX_REPORTS = 100;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] tp;
    logic [COUNT_OUT_W-1:0] tn;
    logic [COUNT_OUT_W-1:0] fp;
    logic [COUNT_OUT_W-1:0] fn;
    logic [RATIO_W-1:0]     recall;
    logic [RATIO_W-1:0]     specificity;
    logic [RATIO_W-1:0]     fp_rate;
    logic [RATIO_W-1:0]     fn_rate;
    logic [PCW_W-1:0]       pct_wrong;
    logic [RATIO_W-1:0]     f_measure;
    logic [RATIO_W-1:0]     precision;
  } frame_stats_t;

  logic [LABEL_W-1:0] shadow_lbl, motion_lbl, ignore_a_lbl, ignore_b_lbl;
  logic [63:0]        n_tp, n_tn, n_fp, n_fn;
  frame_stats_t       expected_frames[$];

  function automatic logic [63:0] bump(logic [63:0] c);
    return (c >= COUNT_CEIL) ? COUNT_CEIL : c + 64'd1;
  endfunction

  // Exact quotient with FRAC_BITS fraction bits, truncated.
  function automatic logic [63:0] ratio_fx(logic [63:0] num, logic [63:0] den);
    return (num << FRAC_BITS) / den;
  endfunction

  function automatic frame_stats_t frame_stats(logic [63:0] tp, logic [63:0] tn,
                                               logic [63:0] fp, logic [63:0] fn);
    frame_stats_t s;
    logic [63:0]  pred_pos, act_pos, act_neg, total, fm;
    pred_pos = tp + fp;
    act_pos  = tp + fn;
    act_neg  = tn + fp;
    total    = tp + tn + fp + fn;
    s.tp = tp[COUNT_OUT_W-1:0];
    s.tn = tn[COUNT_OUT_W-1:0];
    s.fp = fp[COUNT_OUT_W-1:0];
    s.fn = fn[COUNT_OUT_W-1:0];
    s.precision   = RATIO_W'((pred_pos != 0) ? ratio_fx(tp, pred_pos) : UNITY);
    s.recall      = RATIO_W'((act_pos != 0) ? ratio_fx(tp, act_pos) : UNITY);
    s.fn_rate     = RATIO_W'((act_pos != 0) ? ratio_fx(fn, act_pos) : 64'd0);
    s.specificity = RATIO_W'((act_neg != 0) ? ratio_fx(tn, act_neg) : UNITY);
    s.fp_rate     = RATIO_W'((act_neg != 0) ? ratio_fx(fp, act_neg) : 64'd0);
    s.pct_wrong   = PCW_W'((total != 0) ? ratio_fx(PCT_SCALE * (fn + fp), total) : 64'd0);
    // With neither predicted nor actual positives both P and R default to one.
    if (pred_pos == 0 && act_pos == 0) begin
      fm = UNITY;
    end else if (tp == 0) begin
      fm = 64'd0;
    end else begin
      fm = ratio_fx(2 * tp, 2 * tp + fp + fn);
    end
    s.f_measure = RATIO_W'(fm);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] metrics mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin : monitor
    logic [LABEL_W-1:0] truth;
    frame_stats_t       want;
    if (!rst_n) begin
      shadow_lbl   <= SHADOW_RST;
      motion_lbl   <= MOTION_RST;
      ignore_a_lbl <= IGNORE_A_RST;
      ignore_b_lbl <= IGNORE_B_RST;
      n_tp = 0;
      n_tn = 0;
      n_fp = 0;
      n_fn = 0;
      expected_frames.delete();
      mismatches         = 0;
      frames_outstanding = 0;
      frames_checked     = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SHADOW:   shadow_lbl   <= cfg_data;
          REG_MOTION:   motion_lbl   <= cfg_data;
          REG_IGNORE_A: ignore_a_lbl <= cfg_data;
          REG_IGNORE_B: ignore_b_lbl <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result transaction while no frame was pending");
        end else begin
          want = expected_frames.pop_front();
          frames_outstanding--;
          frames_checked++;
          check_field("true_pos", out_true_pos, want.tp);
          check_field("true_neg", out_true_neg, want.tn);
          check_field("false_pos", out_false_pos, want.fp);
          check_field("false_neg", out_false_neg, want.fn);
          check_field("recall", out_recall, want.recall);
          check_field("specificity", out_specificity, want.specificity);
          check_field("false_pos_rate", out_false_pos_rate, want.fp_rate);
          check_field("false_neg_rate", out_false_neg_rate, want.fn_rate);
          check_field("percent_wrong", out_percent_wrong, want.pct_wrong);
          check_field("f_measure", out_f_measure, want.f_measure);
          check_field("precision", out_precision, want.precision);
        end
      end

      if (in_valid && in_ready) begin
        truth = (in_truth_pixel == shadow_lbl) ? motion_lbl : in_truth_pixel;
        if (truth != ignore_a_lbl && truth != ignore_b_lbl) begin
          if (in_test_pixel == truth) begin
            if (in_test_pixel != 0) n_tp = bump(n_tp);
            else                    n_tn = bump(n_tn);
          end else begin
            if (in_test_pixel != 0) n_fp = bump(n_fp);
            else                    n_fn = bump(n_fn);
          end
        end
        if (in_last_pixel) begin
          expected_frames.push_back(frame_stats(n_tp, n_tn, n_fp, n_fn));
          frames_outstanding++;
          n_tp = 0;
          n_tn = 0;
          n_fp = 0;
          n_fn = 0;
        end
      end
    end
  end

endmodule

>>> tb/tb_segmentation_confusion_metrics.sv
// Top of the confusion-metrics testbench. This module only produces stimulus
// (pixel transactions, label register writes and result-side back-pressure)
// and gives the final verdict; all prediction and comparison is done by the
// checker instantiated next to the block.
module tb_segmentation_confusion_metrics;
  import scm_pkg::*;

  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CLK_PERIOD = 4;

  // Time the shared divider takes after a last pixel before the
  // result transaction is offered.
  localparam int RESULT_LATENCY = 7 * (COUNT_BITS + FRAC_BITS + 10) + 1;
  // Quiet time before a label write or the verdict, with some margin on top.
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 20;
  // Long enough for the output register and the internal result to both fill.
  localparam int HOLD_CYCLES    = 3 * RESULT_LATENCY + 100;

  localparam int ITEM_TARGET  = 750;
  localparam int MIN_FRAMES   = 40;
  // From this many pixels on, neither side idles any more.
  localparam int CALM_AFTER   = 650;
  // Worst case is a frame per pixel, each waiting out the divider and the
  // longest idle bursts on both sides; this allows several times that.
  localparam int LIMIT_CYCLES = 2_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [LABEL_W-1:0]     cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [LABEL_W-1:0]     in_test_pixel;
  logic [LABEL_W-1:0]     in_truth_pixel;
  logic                   in_last_pixel;
  logic                   out_valid;
  logic                   out_ready;
  logic [COUNT_OUT_W-1:0] out_true_pos;
  logic [COUNT_OUT_W-1:0] out_true_neg;
  logic [COUNT_OUT_W-1:0] out_false_pos;
  logic [COUNT_OUT_W-1:0] out_false_neg;
  logic [RATIO_W-1:0]     out_recall;
  logic [RATIO_W-1:0]     out_specificity;
  logic [RATIO_W-1:0]     out_false_pos_rate;
  logic [RATIO_W-1:0]     out_false_neg_rate;
  logic [PCW_W-1:0]       out_percent_wrong;
  logic [RATIO_W-1:0]     out_f_measure;
  logic [RATIO_W-1:0]     out_precision;

  int mismatches;
  int frames_outstanding;
  int frames_checked;

  // Stimulus bookkeeping. The label copies only steer the random pixels
  // toward values that matter under the current setting.
  logic [LABEL_W-1:0] lbl_shadow, lbl_motion, lbl_ignore_a, lbl_ignore_b;
  int   pixels_sent  = 0;
  int   frames_sent  = 0;
  int   labels_set   = 0;
  int   holds_done   = 0;
  int   cycle_count  = 0;
  logic calm         = 1'b0;
  logic gaps_on      = 1'b1;
  logic hold_go      = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  segmentation_confusion_metrics #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_test_pixel      (in_test_pixel),
    .in_truth_pixel     (in_truth_pixel),
    .in_last_pixel      (in_last_pixel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_true_pos       (out_true_pos),
    .out_true_neg       (out_true_neg),
    .out_false_pos      (out_false_pos),
    .out_false_neg      (out_false_neg),
    .out_recall         (out_recall),
    .out_specificity    (out_specificity),
    .out_false_pos_rate (out_false_pos_rate),
    .out_false_neg_rate (out_false_neg_rate),
    .out_percent_wrong  (out_percent_wrong),
    .out_f_measure      (out_f_measure),
    .out_precision      (out_precision)
  );

  confusion_metrics_checker #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_test_pixel      (in_test_pixel),
    .in_truth_pixel     (in_truth_pixel),
    .in_last_pixel      (in_last_pixel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_true_pos       (out_true_pos),
    .out_true_neg       (out_true_neg),
    .out_false_pos      (out_false_pos),
    .out_false_neg      (out_false_neg),
    .out_recall         (out_recall),
    .out_specificity    (out_specificity),
    .out_false_pos_rate (out_false_pos_rate),
    .out_false_neg_rate (out_false_neg_rate),
    .out_percent_wrong  (out_percent_wrong),
    .out_f_measure      (out_f_measure),
    .out_precision      (out_precision),
    .mismatches         (mismatches),
    .frames_outstanding (frames_outstanding),
    .frames_checked     (frames_checked)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d frame(s) still pending.",
               cycle_count, frames_outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one pixel transaction and returns at the edge where it is taken.
  // in_ready is sampled on the falling edge, where it is settled, so the
  // handshake decision never races with the block's own updates. While gaps
  // are enabled, an idle burst of random length may precede the pixel.
  task automatic send_pixel(input logic [LABEL_W-1:0] test, input logic [LABEL_W-1:0] truth,
                            input logic last);
    logic taken;
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_test_pixel  <= test;
    in_truth_pixel <= truth;
    in_last_pixel  <= last;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pixels_sent++;
  endtask

  // Truth values are drawn mostly from the labels that the block treats
  // specially, so remaps, skips and matches all occur often.
  function automatic logic [LABEL_W-1:0] pick_truth();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return lbl_motion;
      2:       return lbl_shadow;
      3:       return lbl_ignore_a;
      4:       return lbl_ignore_b;
      default: return LABEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int len);
    int                 i;
    logic [LABEL_W-1:0] truth, test;
    gaps_on = ($urandom_range(0, 3) != 0);
    for (i = 0; i < len; i++) begin
      truth = pick_truth();
      case ($urandom_range(0, 5))
        0, 1:    test = '0;
        2:       test = lbl_motion;
        3:       test = truth;
        default: test = LABEL_W'($urandom_range(0, 255));
      endcase
      send_pixel(test, truth, i == len - 1);
    end
    frames_sent++;
    if (pixels_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  // Mostly short and medium frames, now and then a single pixel or a long one.
  function automatic int random_frame_len();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return $urandom_range(40, 64);
      default: return $urandom_range(2, 24);
    endcase
  endfunction

  // Stops offering pixels and waits until every pending result transaction
  // has been taken. The count is read on the falling edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (frames_outstanding != 0);
    @(posedge clk);
  endtask

  task automatic wait_settled();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_label(input logic [CFG_IDX_W-1:0] idx, input logic [LABEL_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_labels(input logic [LABEL_W-1:0] shadow, input logic [LABEL_W-1:0] motion,
                              input logic [LABEL_W-1:0] ign_a, input logic [LABEL_W-1:0] ign_b);
    write_label(REG_SHADOW, shadow);
    write_label(REG_MOTION, motion);
    write_label(REG_IGNORE_A, ign_a);
    write_label(REG_IGNORE_B, ign_b);
    cfg_wr_en    <= 1'b0;
    lbl_shadow   = shadow;
    lbl_motion   = motion;
    lbl_ignore_a = ign_a;
    lbl_ignore_b = ign_b;
    labels_set++;
  endtask

  // Result side: random ready bursts and stalls, a single long hold-off when
  // the stimulus asks for one, and a steady ready at the end of the run.
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_go) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_go = 1'b0;
        holds_done++;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int                 phase;
    logic [LABEL_W-1:0] r_shadow, r_motion, r_ign_a, r_ign_b;

    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= REG_SHADOW;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_test_pixel  <= '0;
    in_truth_pixel <= '0;
    in_last_pixel  <= 1'b0;
    lbl_shadow     = SHADOW_RST;
    lbl_motion     = MOTION_RST;
    lbl_ignore_a   = IGNORE_A_RST;
    lbl_ignore_b   = IGNORE_B_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset labels (shadow 50, motion 255, ignore
    // 85 and 170). A frame whose only pixel is skipped leaves every counter
    // at zero, so every ratio takes its default.
    send_pixel(8'd0, 8'd85, 1'b1);
    // Only true negatives: precision, recall and F-measure all default to one.
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 1'b1);
    // Only false positives: no true positive, so the F-measure is zero.
    send_pixel(8'd255, 8'd0, 1'b0);
    send_pixel(8'd7, 8'd3, 1'b1);
    // Only false negatives.
    send_pixel(8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd9, 1'b1);
    // A mixed frame with the shadow remap, the second ignore label and the
    // extremes of both label fields.
    send_pixel(8'd255, 8'd50, 1'b0);
    send_pixel(8'd50, 8'd50, 1'b0);
    send_pixel(8'd255, 8'd255, 1'b0);
    send_pixel(8'd1, 8'd1, 1'b0);
    send_pixel(8'd0, 8'd170, 1'b0);
    send_pixel(8'd128, 8'd128, 1'b0);
    send_pixel(8'd0, 8'd1, 1'b0);
    send_pixel(8'd254, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 1'b1);
    // One true positive alone, then a shadow truth against a zero test.
    send_pixel(8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd50, 1'b1);

    // Motion label equal to an ignore label: a shadow truth is then skipped.
    wait_settled();
    apply_labels(8'd0, 8'd85, 8'd85, 8'd255);
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd9, 8'd255, 1'b0);
    send_pixel(8'd85, 8'd50, 1'b0);
    send_pixel(8'd0, 8'd0, 1'b1);

    // Random part, one label setting per phase. Label writes only happen
    // once the block has gone quiet.
    phase = 0;
    forever begin
      wait_settled();
      if (pixels_sent >= ITEM_TARGET && frames_checked >= MIN_FRAMES) break;
      case (phase)
        0: apply_labels(8'd0, 8'd0, 8'd255, 8'd255);
        1: apply_labels(8'd255, 8'd255, 8'd0, 8'd0);
        2: apply_labels(SHADOW_RST, MOTION_RST, IGNORE_A_RST, IGNORE_B_RST);
        default: begin
          r_shadow = LABEL_W'($urandom_range(0, 255));
          r_motion = LABEL_W'($urandom_range(0, 255));
          r_ign_a  = ($urandom_range(0, 3) == 0) ? r_motion : LABEL_W'($urandom_range(0, 255));
          r_ign_b  = ($urandom_range(0, 3) == 0) ? r_shadow : LABEL_W'($urandom_range(0, 255));
          apply_labels(r_shadow, r_motion, r_ign_a, r_ign_b);
        end
      endcase

      if (phase == 1) begin
        // The receiver holds off while short frames keep arriving, so the
        // output register fills, a second result waits inside the block and
        // the pixel channel backs up.
        hold_go = 1'b1;
        repeat (4) send_frame($urandom_range(1, 3));
      end
      if (phase == 2) begin
        // The sender pauses mid-phase until every result has been taken.
        send_frame(random_frame_len());
        wait_drained();
      end
      repeat ($urandom_range(3, 8)) send_frame(random_frame_len());
      phase++;
    end

    $display("Sent %0d pixels in %0d frames; %0d results were checked under %0d label settings.",
             pixels_sent, frames_sent, frames_checked, labels_set);
    $display("The result side held off %0d long time(s) besides its random stalls.",
             holds_done);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> segmentation_confusion_metrics.f
rtl/core/scm_pkg.sv
rtl/core/scm_ctrl.sv
rtl/core/scm_dp.sv
rtl/core/segmentation_confusion_metrics.sv
tb/confusion_metrics_checker.sv
tb/tb_segmentation_confusion_metrics.sv
